>>> rtl/qpwc_pkg.sv
`default_nettype none

package qpwc_pkg;

    parameter int DEF_TABLE_DEPTH = 512;
    parameter int DEF_KEY_BYTES   = 8;

    parameter int KEY_IN_W = 64;
    parameter int LEN_W    = 4;
    parameter int CNT_W    = 16;
    parameter int COLL_W   = 10;

    // djb2 over at most eight bytes stays below 2**53, padded to whole digits
    parameter int HASH_W      = 56;
    parameter int DIGIT_W     = 8;
    parameter int HASH_DIGITS = HASH_W / DIGIT_W;
    parameter int HASH_SHIFT  = 5;

    parameter logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);
    parameter logic [CNT_W-1:0]  COUNT_MAX = '1;
    parameter logic [COLL_W-1:0] COLL_MAX  = '1;

    parameter logic KIND_INSERT = 1'b0;
    parameter logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [KEY_IN_W-1:0] key;
        logic [LEN_W-1:0]    key_length;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [CNT_W-1:0]  count;
        logic              new_entry;
        logic              table_full;
        logic [COLL_W-1:0] collision_count;
    } rsp_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_HASH,
        H_MOD,
        H_DONE
    } hash_state_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } ctrl_state_t;

endpackage

`default_nettype wire

>>> rtl/qpwc_ram.sv
`default_nettype none

module qpwc_ram #(
    parameter int DEPTH = qpwc_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/qpwc_hash.sv
`default_nettype none

module qpwc_hash #(
    parameter int TABLE_DEPTH = qpwc_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = qpwc_pkg::DEF_KEY_BYTES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [8*KEY_BYTES-1:0]           key,
    input  wire logic [qpwc_pkg::LEN_W-1:0]       key_length,
    output logic                                  done,
    output logic      [$clog2(TABLE_DEPTH)-1:0]   home
);

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int REM_W  = IDX_W + 1;
    localparam int MCNT_W = $clog2(qpwc_pkg::HASH_DIGITS);
    localparam logic [REM_W-1:0]  DEPTH_R    = REM_W'(TABLE_DEPTH);
    localparam logic [MCNT_W-1:0] LAST_DIGIT = MCNT_W'(qpwc_pkg::HASH_DIGITS - 1);

    qpwc_pkg::hash_state_t state_reg, state_next;

    logic [qpwc_pkg::HASH_W-1:0] h_reg, h_next;
    logic [KEY_W-1:0]            key_sh_reg, key_sh_next;
    logic [qpwc_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [qpwc_pkg::LEN_W-1:0]  bcnt_reg, bcnt_next;
    logic [MCNT_W-1:0]           mcnt_reg, mcnt_next;
    logic [REM_W-1:0]            r_reg, r_next;
    logic [REM_W-1:0]            rem;
    logic [qpwc_pkg::HASH_W-1:0] byte_ext;
    logic                        bytes_done;

    assign bytes_done = (bcnt_reg == len_reg);
    assign byte_ext   = {{(qpwc_pkg::HASH_W-8){1'b0}}, key_sh_reg[7:0]};

    // one radix-256 digit of remainder reduction per cycle
    always_comb
    begin
        rem = r_reg;
        for (int j = 0; j < qpwc_pkg::DIGIT_W; j++)
        begin
            rem = {rem[REM_W-2:0], h_reg[qpwc_pkg::HASH_W-1-j]};
            if (rem >= DEPTH_R)
            begin
                rem = rem - DEPTH_R;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qpwc_pkg::H_IDLE:
            begin
                if (start)
                begin
                    state_next = qpwc_pkg::H_HASH;
                end
            end
            qpwc_pkg::H_HASH:
            begin
                if (bytes_done)
                begin
                    state_next = qpwc_pkg::H_MOD;
                end
            end
            qpwc_pkg::H_MOD:
            begin
                if (mcnt_reg == LAST_DIGIT)
                begin
                    state_next = qpwc_pkg::H_DONE;
                end
            end
            qpwc_pkg::H_DONE:
            begin
                state_next = qpwc_pkg::H_IDLE;
            end
            default:
            begin
                state_next = qpwc_pkg::H_IDLE;
            end
        endcase
    end

    always_comb
    begin
        h_next      = h_reg;
        key_sh_next = key_sh_reg;
        len_next    = len_reg;
        bcnt_next   = bcnt_reg;
        mcnt_next   = mcnt_reg;
        r_next      = r_reg;
        case (state_reg)
            qpwc_pkg::H_IDLE:
            begin
                if (start)
                begin
                    h_next      = qpwc_pkg::HASH_SEED;
                    key_sh_next = key;
                    len_next    = key_length;
                    bcnt_next   = '0;
                    mcnt_next   = '0;
                    r_next      = '0;
                end
            end
            qpwc_pkg::H_HASH:
            begin
                if (!bytes_done)
                begin
                    h_next      = (h_reg << qpwc_pkg::HASH_SHIFT) + h_reg + byte_ext;
                    key_sh_next = key_sh_reg >> 8;
                    bcnt_next   = bcnt_reg + 1'b1;
                end
            end
            qpwc_pkg::H_MOD:
            begin
                r_next    = rem;
                h_next    = h_reg << qpwc_pkg::DIGIT_W;
                mcnt_next = mcnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        done = (state_reg == qpwc_pkg::H_DONE);
        home = r_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qpwc_pkg::H_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        key_sh_reg <= key_sh_next;
        len_reg    <= len_next;
        bcnt_reg   <= bcnt_next;
        mcnt_reg   <= mcnt_next;
        r_reg      <= r_next;
    end

endmodule

`default_nettype wire

>>> rtl/quadratic_probe_word_counter.sv
// hashing folds in the key bytes one at a time, the modulo unit then reduces the hash digit by digit, each probe
// is one table read followed by one compare and update on the table RAM
// one item at a time: the next request is taken only after the response is registered
// reset: after rst_n rises a clearing pass walks all TABLE_DEPTH slots, one per cycle,
// with req_ready low; collision total and output valid are cleared at once
`default_nettype none

module quadratic_probe_word_counter #(
    parameter int TABLE_DEPTH = qpwc_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = qpwc_pkg::DEF_KEY_BYTES
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire qpwc_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output qpwc_pkg::rsp_t      rsp
);

    localparam int KEY_W   = 8 * KEY_BYTES;
    localparam int LEN_W   = qpwc_pkg::LEN_W;
    localparam int CNT_W   = qpwc_pkg::CNT_W;
    localparam int COLL_W  = qpwc_pkg::COLL_W;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int PCNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W  = 1 + LEN_W + CNT_W + KEY_W;
    localparam int CNT_LO  = KEY_W;
    localparam int LEN_LO  = KEY_W + CNT_W;
    localparam logic [IDX_W:0]    DEPTH_S    = (IDX_W+1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [PCNT_W-1:0] LAST_PROBE = PCNT_W'(TABLE_DEPTH - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(KEY_BYTES);

    qpwc_pkg::ctrl_state_t state_reg, state_next;

    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic              kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [PCNT_W-1:0] probe_reg, probe_next;
    logic [COLL_W-1:0] coll_reg, coll_next;
    qpwc_pkg::rsp_t    res_reg, res_next;
    qpwc_pkg::rsp_t    rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [LEN_W-1:0]  len_eff;
    logic [KEY_W-1:0]  key_mask;
    logic              req_xfer;
    logic              hash_done;
    logic [IDX_W-1:0]  home;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [WORD_W-1:0] mem_rdata;

    logic              rd_used;
    logic [LEN_W-1:0]  rd_len;
    logic [CNT_W-1:0]  rd_cnt;
    logic [KEY_W-1:0]  rd_key;
    logic              hit;
    logic              free;
    logic              last;
    logic              is_insert;
    logic [CNT_W-1:0]  cnt_new;
    logic [IDX_W:0]    idx_sum;
    logic [IDX_W:0]    step_sum;
    logic              rsp_free;

    assign req_xfer  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign is_insert = (kind_reg == qpwc_pkg::KIND_INSERT);

    always_comb
    begin
        len_eff = (req.key_length > MAX_LEN) ? MAX_LEN : req.key_length;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            key_mask[8*b +: 8] = (LEN_W'(b) < len_eff) ? req.key[8*b +: 8] : 8'h00;
        end
    end

    qpwc_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (req_xfer),
        .key        (key_mask),
        .key_length (len_eff),
        .done       (hash_done),
        .home       (home)
    );

    qpwc_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    assign rd_used = mem_rdata[WORD_W-1];
    assign rd_len  = mem_rdata[LEN_LO +: LEN_W];
    assign rd_cnt  = mem_rdata[CNT_LO +: CNT_W];
    assign rd_key  = mem_rdata[KEY_W-1:0];

    assign hit     = rd_used && (rd_key == key_reg) && (rd_len == len_reg);
    assign free    = !rd_used;
    assign last    = (probe_reg == LAST_PROBE);
    assign cnt_new = hit ? ((is_insert && (rd_cnt != qpwc_pkg::COUNT_MAX)) ?
                            rd_cnt + 1'b1 : rd_cnt)
                         : CNT_W'(1);

    // quadratic step: offset i*i grows by 2i+1, both kept modulo the depth
    assign idx_sum  = {1'b0, idx_reg} + {1'b0, step_reg};
    assign step_sum = {1'b0, step_reg} + (IDX_W+1)'(2);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qpwc_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = qpwc_pkg::ST_IDLE;
                end
            end
            qpwc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = qpwc_pkg::ST_HASH;
                end
            end
            qpwc_pkg::ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = qpwc_pkg::ST_READ;
                end
            end
            qpwc_pkg::ST_READ:
            begin
                state_next = qpwc_pkg::ST_CHECK;
            end
            qpwc_pkg::ST_CHECK:
            begin
                if (hit || free || last)
                begin
                    state_next = qpwc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = qpwc_pkg::ST_READ;
                end
            end
            qpwc_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = qpwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qpwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = (state_reg == qpwc_pkg::ST_IDLE);
        mem_re    = (state_reg == qpwc_pkg::ST_READ);
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {1'b1, len_reg, cnt_new, key_reg};
        case (state_reg)
            qpwc_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            qpwc_pkg::ST_CHECK:
            begin
                mem_we = is_insert && (hit || free);
            end
            default:
            begin
            end
        endcase
        rsp_valid = rsp_valid_reg;
        rsp       = rsp_reg;
    end

    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        probe_next     = probe_reg;
        coll_next      = coll_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            qpwc_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            qpwc_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    kind_next = req.kind;
                    key_next  = key_mask;
                    len_next  = len_eff;
                end
            end
            qpwc_pkg::ST_HASH:
            begin
                idx_next   = home;
                step_next  = IDX_W'(1);
                probe_next = '0;
            end
            qpwc_pkg::ST_CHECK:
            begin
                res_next.found           = hit;
                res_next.count           = '0;
                res_next.new_entry       = 1'b0;
                res_next.table_full      = 1'b0;
                res_next.collision_count = coll_reg;
                if (hit)
                begin
                    res_next.count = cnt_new;
                end
                else if (free)
                begin
                    if (is_insert)
                    begin
                        res_next.count     = CNT_W'(1);
                        res_next.new_entry = 1'b1;
                        if ((probe_reg != '0) && (coll_reg != qpwc_pkg::COLL_MAX))
                        begin
                            coll_next                = coll_reg + 1'b1;
                            res_next.collision_count = coll_reg + 1'b1;
                        end
                    end
                end
                else if (last)
                begin
                    res_next.table_full = is_insert;
                end
                else
                begin
                    idx_next   = (idx_sum >= DEPTH_S) ? IDX_W'(idx_sum - DEPTH_S)
                                                      : idx_sum[IDX_W-1:0];
                    step_next  = (step_sum >= DEPTH_S) ? IDX_W'(step_sum - DEPTH_S)
                                                       : step_sum[IDX_W-1:0];
                    probe_next = probe_reg + 1'b1;
                end
            end
            qpwc_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qpwc_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            coll_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            coll_reg      <= coll_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        probe_reg <= probe_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

endmodule

`default_nettype wire

>>> rtl/qpwc_checker.sv
`default_nettype none

module qpwc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire qpwc_pkg::rsp_t rsp
);

    logic [qpwc_pkg::COLL_W-1:0] last_coll_reg;

    // collision total seen at the last response transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_coll_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            last_coll_reg <= rsp.collision_count;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.found || rsp.new_entry) |->
            rsp.count != '0 && !(rsp.found && rsp.new_entry) && !rsp.table_full)
        else $error("inconsistent hit or create response");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.table_full |-> rsp.count == '0)
        else $error("full table response carries a count");

    a_coll_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.collision_count >= last_coll_reg)
        else $error("collision total went backwards");

endmodule

bind quadratic_probe_word_counter qpwc_checker u_qpwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

>>> dv/quadratic_probe_word_counter_tb.sv
`timescale 1ns / 1ps

module quadratic_probe_word_counter_tb;

    localparam int DEPTH          = qpwc_pkg::DEF_TABLE_DEPTH;
    localparam int MAX_BYTES      = qpwc_pkg::DEF_KEY_BYTES;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int HOLD_CYCLES    = 300;
    localparam int FLOOD_KEYS     = 120;
    localparam int POOL_SIZE      = 48;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    qpwc_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    qpwc_pkg::rsp_t rsp;

    qpwc_pkg::req_t pending_q [$];
    qpwc_pkg::rsp_t expected_q [$];

    bit        slot_used [DEPTH];
    bit [63:0] slot_key [DEPTH];
    bit [3:0]  slot_len [DEPTH];
    bit [15:0] slot_cnt [DEPTH];
    bit [9:0]  collisions;

    bit [63:0] pool_key [POOL_SIZE];
    bit [3:0]  pool_len [POOL_SIZE];

    int send_idle_pct = 31;
    int recv_idle_pct = 46;
    int errors        = 0;
    int rsp_seen      = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    bit req_fire      = 1'b0;
    bit rsp_fire;

    quadratic_probe_word_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit [3:0] eff_len(bit [3:0] len);
        return (len > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : len;
    endfunction

    function automatic bit [63:0] byte_mask(bit [3:0] len);
        bit [3:0] n;
        n = eff_len(len);
        return (n >= 4'd8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic int home_slot(bit [63:0] key, bit [3:0] len);
        bit [63:0] h;
        bit [3:0]  n;
        n = eff_len(len);
        h = 64'(qpwc_pkg::HASH_SEED);
        for (int b = 0; b < n; b++)
            h = (h << qpwc_pkg::HASH_SHIFT) + h + 64'(key[8*b +: 8]);
        return int'(h % DEPTH);
    endfunction

    function automatic qpwc_pkg::rsp_t count_word(qpwc_pkg::req_t r);
        qpwc_pkg::rsp_t res;
        bit [3:0]       n;
        bit [63:0]      k;
        int             home;
        int             idx;
        bit             done;
        res  = '0;
        n    = eff_len(r.key_length);
        k    = r.key & byte_mask(n);
        home = home_slot(k, n);
        done = 1'b0;
        for (int i = 0; i < DEPTH && !done; i++)
        begin
            idx = (home + i * i) % DEPTH;
            if (!slot_used[idx])
            begin
                if (r.kind == qpwc_pkg::KIND_INSERT)
                begin
                    slot_used[idx] = 1'b1;
                    slot_key[idx]  = k;
                    slot_len[idx]  = n;
                    slot_cnt[idx]  = 16'd1;
                    if (i > 0 && collisions != qpwc_pkg::COLL_MAX)
                        collisions++;
                    res.count     = 16'd1;
                    res.new_entry = 1'b1;
                end
                done = 1'b1;
            end
            else if (slot_key[idx] == k && slot_len[idx] == n)
            begin
                if (r.kind == qpwc_pkg::KIND_INSERT && slot_cnt[idx] != qpwc_pkg::COUNT_MAX)
                    slot_cnt[idx]++;
                res.found = 1'b1;
                res.count = slot_cnt[idx];
                done      = 1'b1;
            end
        end
        res.table_full      = !done && r.kind == qpwc_pkg::KIND_INSERT;
        res.collision_count = collisions;
        return res;
    endfunction

    function automatic qpwc_pkg::req_t make_req(logic kind, bit [63:0] key, bit [3:0] len);
        qpwc_pkg::req_t r;
        r.kind       = kind;
        r.key        = key;
        r.key_length = len;
        return r;
    endfunction

    function automatic bit [63:0] rand_key();
        bit [63:0] k;
        for (int b = 0; b < 8; b++)
            k[8*b +: 8] = ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom);
        return k;
    endfunction

    function automatic bit [3:0] rand_len();
        return ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
    endfunction

    function automatic bit [63:0] key_at_home(int home);
        bit [63:0] k;
        k = {$urandom, $urandom};
        while (home_slot(k, 4'd8) != home)
            k = {$urandom, $urandom};
        return k;
    endfunction

    task automatic push_random(int n);
        int        p;
        bit [63:0] junk;
        bit [63:0] m;
        logic      kind;
        for (int j = 0; j < n; j++)
        begin
            kind = $urandom_range(1) ? qpwc_pkg::KIND_LOOKUP : qpwc_pkg::KIND_INSERT;
            if ($urandom_range(99) < 70)
            begin
                // known word, random bytes past its length
                p    = $urandom_range(POOL_SIZE - 1);
                m    = byte_mask(pool_len[p]);
                junk = $urandom_range(1) ? {$urandom, $urandom} : 64'd0;
                pending_q.push_back(make_req(kind, (pool_key[p] & m) | (junk & ~m),
                                             pool_len[p]));
            end
            else
                pending_q.push_back(make_req(kind, rand_key(), rand_len()));
        end
    endtask

    // fill one probe chain until inserts run out of slots
    task automatic push_flood();
        bit [63:0] fk [FLOOD_KEYS];
        int        home;
        home = $urandom_range(DEPTH - 1);
        for (int j = 0; j < FLOOD_KEYS; j++)
        begin
            fk[j] = key_at_home(home);
            pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, fk[j], 4'd8));
        end
        for (int j = 0; j < 4; j++)
        begin
            pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, fk[j], 4'd8));
            pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, fk[FLOOD_KEYS - 1 - j], 4'd8));
        end
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, key_at_home(home), 4'd8));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, key_at_home(home), 4'd8));
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= pending_q.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response sink with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && rsp_seen >= 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_fire = req_valid && req_ready;
            rsp_fire = rsp_valid && rsp_ready;
            if (rsp_fire)
            begin
                rsp_seen++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: response transfer with nothing expected, count %0d",
                             $time, rsp.count);
                end
                else
                begin
                    qpwc_pkg::rsp_t want;
                    want = expected_q.pop_front();
                    check_field("found", 16'(want.found), 16'(rsp.found));
                    check_field("count", want.count, rsp.count);
                    check_field("new_entry", 16'(want.new_entry), 16'(rsp.new_entry));
                    check_field("table_full", 16'(want.table_full), 16'(rsp.table_full));
                    check_field("collision_count", 16'(want.collision_count),
                                16'(rsp.collision_count));
                end
            end
            if (req_fire)
                expected_q.push_back(count_word(req));
            quiet_cycles = (req_fire || rsp_fire) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        bit [63:0] c1;
        bit [63:0] c2;
        int        a_home;
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            pool_key[p] = rand_key();
            pool_len[p] = rand_len();
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        a_home = home_slot(64'h61, 4'd1);
        c1     = key_at_home(a_home);
        c2     = key_at_home(a_home);
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, 64'h61, 4'd1));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FF61, 4'd1));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, 64'h61, 4'd1));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, 64'h62, 4'd1));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, '1, 4'd0));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, 64'd0, 4'd0));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, '1, 4'd15));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, '1, 4'd8));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, '1, 4'd9));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, 64'd0, 4'd8));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, 64'd0, 4'd3));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, 64'hABCD_0000_0000_0000, 4'd3));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, 64'h5555_5555_5555_5555, 4'd8));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd7));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, 64'h00AA_AAAA_AAAA_AAAA, 4'd7));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, 64'h5555_5555_5555_5555, 4'd4));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, 64'h0000_0000_0000_6261, 4'd2));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, c1, 4'd8));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, c1, 4'd8));
        pending_q.push_back(make_req(qpwc_pkg::KIND_INSERT, c2, 4'd8));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, c2, 4'd8));
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, key_at_home(a_home), 4'd8));
        push_random(260);
        drain();

        send_idle_pct = 46;
        recv_idle_pct = 31;
        push_random(120);
        push_flood();
        push_random(110);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(200);
        pending_q.push_back(make_req(qpwc_pkg::KIND_LOOKUP, 64'h61, 4'd1));
        drain();

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
